// File: hdl/cblru_pkg.sv
// shared constants and codes for the cost-budget lru cache
`timescale 1ns / 1ps
package cblru_pkg;
  localparam int SLOTS_DEF = 16;
  localparam int BUDGET_W = 36;
  localparam int WORD_W = 32;
  localparam int STATUS_W = 3;
  localparam int EVCNT_W = 5;
  localparam int MODE_W = 2;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 36'd536870912;
  localparam logic [EVCNT_W-1:0] EVCNT_MAX = 5'd31;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_ACCESS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STALE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_COSTLY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_TRIMMED  = 3'd6;
endpackage

// File: hdl/cblru_if.sv
// channel interfaces for request, result and budget words
`timescale 1ns / 1ps
interface cblru_in_if;
  logic valid;
  logic ready;
  logic [cblru_pkg::MODE_W-1:0] mode;
  logic [cblru_pkg::WORD_W-1:0] key;
  logic [cblru_pkg::WORD_W-1:0] size_bytes;
  logic [cblru_pkg::WORD_W-1:0] stamp;
  modport source (output valid, mode, key, size_bytes, stamp, input ready);
  modport sink (input valid, mode, key, size_bytes, stamp, output ready);
endinterface

interface cblru_out_if;
  logic valid;
  logic ready;
  logic [cblru_pkg::STATUS_W-1:0] status;
  logic [cblru_pkg::EVCNT_W-1:0] evicted_count;
  logic [cblru_pkg::BUDGET_W-1:0] total_bytes;
  modport source (output valid, status, evicted_count, total_bytes, input ready);
  modport sink (input valid, status, evicted_count, total_bytes, output ready);
endinterface

interface cblru_cfg_if;
  logic valid;
  logic ready;
  logic [cblru_pkg::BUDGET_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hdl/cblru_ram.sv
// generic ram, one write port and one registered read port
`timescale 1ns / 1ps
module cblru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/cost_budget_lru_cache_core.sv
// LRU cache with byte budget: one request, one result word.
// A request passes through an accept step, the key lookup walking the entry
// ram one slot a cycle (stopping at the first match), a decide step and, for
// an insert, an insert step and a budget check, then a result step; a trim
// request (top mode bit set) goes from accept straight to the budget check.
// Each eviction to meet the budget adds a victim cost read, a drop and a
// budget recheck, since it reads the victim's cost from the ram; making room
// in a full cache adds a cost read and a drop. Recency ranks and valid bits
// live in flip-flops and are updated for all slots at once. The next request
// is taken while the previous result still waits on the output register. Budget
// writes are taken at any time but must only be made while the cache is idle.
`timescale 1ns / 1ps
module cost_budget_lru_cache_core #(
  parameter int SLOTS = cblru_pkg::SLOTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  cblru_in_if.sink    in_ch,
  cblru_out_if.source out_ch,
  cblru_cfg_if.sink   cfg_ch
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int TW = cblru_pkg::BUDGET_W + 1;
  localparam int WW = cblru_pkg::WORD_W;
  localparam int DW = 3 * WW;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_INSERT, S_EVICT, S_EV_RD, S_EV_DO, S_DONE
  } state_t;

  state_t state_r;
  logic [cblru_pkg::BUDGET_W-1:0] budget_r;
  logic [cblru_pkg::MODE_W-1:0] mode_r;
  logic [WW-1:0] key_r, cost_r, stamp_r;
  logic [IW-1:0] idx_r, chk_idx_r, s_r, ev_s_r;
  logic chk_v_r, found_r, full_r;
  logic [WW-1:0] s_stamp_r, s_cost_r;
  logic [cblru_pkg::STATUS_W-1:0] status_r;
  logic [cblru_pkg::EVCNT_W-1:0] evcnt_r;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [IW-1:0] age_r [SLOTS];
  logic [IW-1:0] age_nxt [SLOTS];
  logic [CW-1:0] count_r, count_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic out_valid_r;
  logic [cblru_pkg::STATUS_W-1:0] out_status_r;
  logic [cblru_pkg::EVCNT_W-1:0] out_evcnt_r;
  logic [cblru_pkg::BUDGET_W-1:0] out_total_r;
  logic out_load;

  // ram and its ports
  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic [WW-1:0] rd_key, rd_stamp, rd_cost;

  // slot update controls
  logic drop_en, recent_en, ins_en;
  logic [IW-1:0] drop_idx;
  logic [WW-1:0] drop_cost;
  logic [IW-1:0] free_idx, old_idx;
  logic [IW-1:0] oldest_age;

  cblru_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rd_key = rdata[DW-1 -: WW];
  assign rd_stamp = rdata[2*WW-1 -: WW];
  assign rd_cost = rdata[WW-1:0];

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.evicted_count = out_evcnt_r;
  assign out_ch.total_bytes = out_total_r;

  // result register takes a new word
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // first free slot and least recent slot
  assign oldest_age = IW'(count_r - CW'(1));
  always_comb begin
    free_idx = '0;
    old_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
      if (valid_r[i] && age_r[i] == oldest_age) begin
        old_idx = IW'(i);
      end
    end
  end

  // ram access per state
  assign raddr = (state_r == S_EV_RD) ? old_idx : idx_r;
  assign we = (state_r == S_INSERT);
  assign waddr = free_idx;
  assign wdata = {key_r, stamp_r, cost_r};

  // which slot operation runs this cycle
  always_comb begin
    drop_en = 1'b0;
    recent_en = 1'b0;
    ins_en = 1'b0;
    drop_idx = s_r;
    drop_cost = s_cost_r;
    unique case (state_r)
      S_DECIDE: begin
        if (found_r) begin
          if (mode_r == cblru_pkg::MODE_ACCESS && s_stamp_r >= stamp_r) begin
            recent_en = 1'b1;
          end else begin
            drop_en = 1'b1;
          end
        end
      end
      S_INSERT: ins_en = 1'b1;
      S_EV_DO: begin
        drop_en = 1'b1;
        drop_idx = ev_s_r;
        drop_cost = rd_cost;
      end
      default: ;
    endcase
  end

  // next ranks, valid bits, count and total
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    total_nxt = total_r;
    for (int i = 0; i < SLOTS; i++) begin
      age_nxt[i] = age_r[i];
    end
    if (drop_en) begin
      total_nxt = (total_r >= TW'(drop_cost)) ? total_r - TW'(drop_cost) : '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (valid_r[i] && IW'(i) != drop_idx && age_r[i] > age_r[drop_idx]) begin
          age_nxt[i] = age_r[i] - IW'(1);
        end
      end
      valid_nxt[drop_idx] = 1'b0;
      count_nxt = count_r - CW'(1);
    end else if (recent_en) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (valid_r[i] && IW'(i) != s_r && age_r[i] < age_r[s_r]) begin
          age_nxt[i] = age_r[i] + IW'(1);
        end
      end
      age_nxt[s_r] = '0;
    end else if (ins_en) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (valid_r[i]) begin
          age_nxt[i] = age_r[i] + IW'(1);
        end
      end
      age_nxt[free_idx] = '0;
      valid_nxt[free_idx] = 1'b1;
      count_nxt = count_r + CW'(1);
      total_nxt = total_r + TW'(cost_r);
    end
  end

  // slot state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      total_r <= '0;
      budget_r <= cblru_pkg::BUDGET_RESET;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
      if (cfg_ch.valid) begin
        budget_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      age_r[i] <= age_nxt[i];
    end
  end

  // sequencer with result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      chk_v_r <= 1'b0;
      full_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode_r <= in_ch.mode;
            key_r <= in_ch.key;
            cost_r <= (in_ch.size_bytes == '0) ? WW'(1) : in_ch.size_bytes;
            stamp_r <= in_ch.stamp;
            idx_r <= '0;
            chk_v_r <= 1'b0;
            found_r <= 1'b0;
            full_r <= 1'b0;
            evcnt_r <= '0;
            if (in_ch.mode[1]) begin
              status_r <= cblru_pkg::ST_TRIMMED;
              state_r <= S_EVICT;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          idx_r <= idx_r + IW'(1);
          chk_idx_r <= idx_r;
          if (chk_v_r && valid_r[chk_idx_r] && rd_key == key_r) begin
            found_r <= 1'b1;
            s_r <= chk_idx_r;
            s_stamp_r <= rd_stamp;
            s_cost_r <= rd_cost;
            chk_v_r <= 1'b0;
            state_r <= S_DECIDE;
          end else if (chk_v_r && chk_idx_r == IW'(SLOTS - 1)) begin
            chk_v_r <= 1'b0;
            state_r <= S_DECIDE;
          end else begin
            chk_v_r <= 1'b1;
          end
        end
        S_DECIDE: begin
          if (mode_r == cblru_pkg::MODE_REMOVE) begin
            status_r <= found_r ? cblru_pkg::ST_REMOVED : cblru_pkg::ST_ABSENT;
            state_r <= S_DONE;
          end else if (found_r && s_stamp_r >= stamp_r) begin
            status_r <= cblru_pkg::ST_HIT;
            state_r <= S_DONE;
          end else begin
            if ({4'b0, cost_r} > budget_r) begin
              status_r <= cblru_pkg::ST_COSTLY;
              state_r <= S_DONE;
            end else begin
              status_r <= found_r ? cblru_pkg::ST_STALE : cblru_pkg::ST_INSERTED;
              if (!found_r && count_r == CW'(SLOTS)) begin
                full_r <= 1'b1;
                state_r <= S_EV_RD;
              end else begin
                state_r <= S_INSERT;
              end
            end
          end
        end
        S_INSERT: state_r <= S_EVICT;
        S_EVICT: begin
          if (total_r > TW'(budget_r) && count_r != '0) begin
            state_r <= S_EV_RD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_EV_RD: begin
          ev_s_r <= old_idx;
          state_r <= S_EV_DO;
        end
        S_EV_DO: begin
          if (evcnt_r != cblru_pkg::EVCNT_MAX) begin
            evcnt_r <= evcnt_r + cblru_pkg::EVCNT_W'(1);
          end
          if (full_r) begin
            full_r <= 1'b0;
            state_r <= S_INSERT;
          end else begin
            state_r <= S_EVICT;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_status_r <= status_r;
            out_evcnt_r <= evcnt_r;
            out_total_r <= total_r[cblru_pkg::BUDGET_W-1:0];
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // fill count tracks the valid bits
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CW'($countones(valid_r)))
    else $error("fill count out of step with valid bits");

  // every eviction drop follows its cost read
  a_evseq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EV_DO |-> $past(state_r) == S_EV_RD)
    else $error("eviction without cost read");

  // a new result carries the running total
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_total_r == total_r[cblru_pkg::BUDGET_W-1:0])
    else $error("result total differs from running total");
`endif
endmodule
